// ===== rtl/dnlr_pkg.sv =====
// dnlr_pkg: character classes, recogniser state codes and queue sizing
// shared by all modules of the decimal number literal recogniser
// no dependencies
`timescale 1ns / 1ps

package dnlr_pkg;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = 1;
    localparam int QCNT_W = 2;

    typedef enum logic [2:0] {
        CLS_DIGIT = 3'd0,
        CLS_SIGN  = 3'd1,
        CLS_DOT   = 3'd2,
        CLS_EXP   = 3'd3,
        CLS_OTHER = 3'd4,
        CLS_END   = 3'd5
    } cls_t;

    typedef enum logic [8:0] {
        ST_START      = 9'b000000001,
        ST_SIGN       = 9'b000000010,
        ST_INT        = 9'b000000100,
        ST_DOT_NO_INT = 9'b000001000,
        ST_FRAC       = 9'b000010000,
        ST_EXP        = 9'b000100000,
        ST_EXP_SIGN   = 9'b001000000,
        ST_EXP_DIGITS = 9'b010000000,
        ST_ERROR      = 9'b100000000
    } state_t;

    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_UPPER_E = 8'h45;
    localparam logic [7:0] CH_LOWER_E = 8'h65;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

endpackage

// ===== rtl/decimal_number_literal_recognizer.sv =====
// decimal_number_literal_recognizer: top level, classifier, queue and recogniser
// depends on dnlr_pkg, dnlr_front, dnlr_queue, dnlr_back
//
// channel  signals                         beat
// input    in_valid/in_ready               symbol, end_marker
// output   out_valid/out_ready             is_number (one per end marker)
//
// one beat per cycle sustained while the output does not stall; an end marker's class
// is queued, popped into the recogniser and its verdict loaded into the output register
// reset returns the recogniser to its start state and empties the queue
// output stalls fill the queue and delay verdicts; input stalls only leave the recogniser idle
`timescale 1ns / 1ps

module decimal_number_literal_recognizer (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] symbol,
    input  logic       end_marker,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       is_number
);
    import dnlr_pkg::*;

    cls_t in_cls;
    cls_t q_cls;
    logic q_valid;
    logic q_ready;

    dnlr_front u_front (
        .symbol     (symbol),
        .end_marker (end_marker),
        .cls        (in_cls)
    );

    dnlr_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (in_valid),
        .push_ready (in_ready),
        .push_cls   (in_cls),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_cls    (q_cls)
    );

    dnlr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (q_valid),
        .pop_ready (q_ready),
        .pop_cls   (q_cls),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .is_number (is_number)
    );

endmodule

// ===== rtl/dnlr_front.sv =====
// dnlr_front: classifies each incoming beat into a character class
// depends on dnlr_pkg
`timescale 1ns / 1ps

module dnlr_front (
    input  logic [7:0]    symbol,
    input  logic          end_marker,
    output dnlr_pkg::cls_t cls
);
    import dnlr_pkg::*;

    always_comb
    begin
        if (end_marker)
        begin
            cls = CLS_END;
        end
        else if (symbol >= CH_ZERO && symbol <= CH_NINE)
        begin
            cls = CLS_DIGIT;
        end
        else if (symbol == CH_PLUS || symbol == CH_MINUS)
        begin
            cls = CLS_SIGN;
        end
        else if (symbol == CH_DOT)
        begin
            cls = CLS_DOT;
        end
        else if (symbol == CH_UPPER_E || symbol == CH_LOWER_E)
        begin
            cls = CLS_EXP;
        end
        else
        begin
            cls = CLS_OTHER;
        end
    end

endmodule

// ===== rtl/dnlr_queue.sv =====
// dnlr_queue: short class queue between the classifier and the recogniser
// depends on dnlr_pkg
`timescale 1ns / 1ps

module dnlr_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    output logic           push_ready,
    input  dnlr_pkg::cls_t push_cls,
    output logic           pop_valid,
    input  logic           pop_ready,
    output dnlr_pkg::cls_t pop_cls
);
    import dnlr_pkg::*;

    cls_t              q_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              push;
    logic              pop;

    assign push_ready = (count_reg != QCNT_W'(QDEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_cls    = q_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= push_cls;
        end
    end

endmodule

// ===== rtl/dnlr_back.sv =====
// dnlr_back: recogniser state machine and verdict output register
// depends on dnlr_pkg
`timescale 1ns / 1ps

module dnlr_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           pop_valid,
    output logic           pop_ready,
    input  dnlr_pkg::cls_t pop_cls,
    output logic           out_valid,
    input  logic           out_ready,
    output logic           is_number
);
    import dnlr_pkg::*;

    state_t state_reg;
    state_t state_next;
    state_t step_state;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   is_number_reg;
    logic   is_number_next;
    logic   pop;
    logic   accepting;

    assign pop_ready = !out_valid_reg || out_ready;
    assign pop       = pop_valid && pop_ready;
    assign out_valid = out_valid_reg;
    assign is_number = is_number_reg;
    assign accepting = (state_reg == ST_INT) || (state_reg == ST_FRAC)
                       || (state_reg == ST_EXP_DIGITS);

    // transition on one character class
    always_comb
    begin
        step_state = ST_ERROR;
        unique case (state_reg)
            ST_START:
            begin
                case (pop_cls)
                    CLS_SIGN:  step_state = ST_SIGN;
                    CLS_DIGIT: step_state = ST_INT;
                    CLS_DOT:   step_state = ST_DOT_NO_INT;
                    default:   step_state = ST_ERROR;
                endcase
            end
            ST_SIGN:
            begin
                case (pop_cls)
                    CLS_DIGIT: step_state = ST_INT;
                    CLS_DOT:   step_state = ST_DOT_NO_INT;
                    default:   step_state = ST_ERROR;
                endcase
            end
            ST_INT:
            begin
                case (pop_cls)
                    CLS_DIGIT: step_state = ST_INT;
                    CLS_DOT:   step_state = ST_FRAC;
                    CLS_EXP:   step_state = ST_EXP;
                    default:   step_state = ST_ERROR;
                endcase
            end
            ST_DOT_NO_INT:
            begin
                step_state = (pop_cls == CLS_DIGIT) ? ST_FRAC : ST_ERROR;
            end
            ST_FRAC:
            begin
                case (pop_cls)
                    CLS_DIGIT: step_state = ST_FRAC;
                    CLS_EXP:   step_state = ST_EXP;
                    default:   step_state = ST_ERROR;
                endcase
            end
            ST_EXP:
            begin
                case (pop_cls)
                    CLS_SIGN:  step_state = ST_EXP_SIGN;
                    CLS_DIGIT: step_state = ST_EXP_DIGITS;
                    default:   step_state = ST_ERROR;
                endcase
            end
            ST_EXP_SIGN, ST_EXP_DIGITS:
            begin
                step_state = (pop_cls == CLS_DIGIT) ? ST_EXP_DIGITS : ST_ERROR;
            end
            default:
            begin
                step_state = ST_ERROR;
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        is_number_next = is_number_reg;
        if (pop)
        begin
            if (pop_cls == CLS_END)
            begin
                state_next     = ST_START;
                out_valid_next = 1'b1;
                is_number_next = accepting;
            end
            else
            begin
                state_next = step_state;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_START;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        is_number_reg <= is_number_next;
    end

endmodule
